// File: src/kra_pkg.sv
// Package for keyed_running_average: controller state type and fixed widths.
// No dependencies.
package kra_pkg;

  localparam int KeyW   = 64;
  localparam int ValW   = 32;
  localparam int CntW   = 32;
  localparam int SumW   = 64;
  localparam int DivCntW = 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_KEY,
    S_CMP_KEY,
    S_RD_DATA,
    S_UPDATE,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// File: src/kra_div.sv
// Bit-serial restoring divider: 64-bit magnitude by 32-bit count, one quotient
// bit per cycle, result clamped to signed 32 bits. Uses kra_pkg.
module kra_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [kra_pkg::SumW-1:0]  mag,
  input  logic                      neg,
  input  logic [kra_pkg::CntW-1:0]  divisor,
  output logic                      done,
  output logic [kra_pkg::ValW-1:0]  mean
);

  logic [kra_pkg::SumW-1:0]    quo;
  logic [kra_pkg::CntW-1:0]    rem;
  logic [kra_pkg::CntW-1:0]    dvs;
  logic                        sgn;
  logic                        run;
  logic [kra_pkg::DivCntW-1:0] cnt;
  logic [kra_pkg::CntW:0]      shifted;
  logic [kra_pkg::CntW:0]      diff;
  logic                        ge;
  logic [kra_pkg::SumW-1:0]    q_pos;
  logic [kra_pkg::SumW-1:0]    q_neg;

  assign shifted = {rem, quo[kra_pkg::SumW-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = !diff[kra_pkg::CntW];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == kra_pkg::DivCntW'(kra_pkg::SumW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag;
      rem <= '0;
      dvs <= divisor;
      sgn <= neg;
    end else if (run) begin
      rem <= ge ? diff[kra_pkg::CntW-1:0] : shifted[kra_pkg::CntW-1:0];
      quo <= {quo[kra_pkg::SumW-2:0], ge};
    end
  end

  always_comb begin
    q_pos = (quo > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : quo;
    q_neg = (quo > 64'h8000_0000) ? 64'h8000_0000 : quo;
    q_neg = 64'd0 - q_neg;
    mean  = sgn ? q_neg[kra_pkg::ValW-1:0] : q_pos[kra_pkg::ValW-1:0];
  end

endmodule

// File: src/keyed_running_average.sv
// Top level of keyed_running_average: key table, scan/update sequencer.
// Depends on kra_pkg and kra_div.
//
// Usage: present sample_key, sample_value and batch_last with start high;
// the transfer happens at the clock edge where start is high and busy low.
// busy stays high while the item is worked on. The key table is scanned one
// slot at a time, each slot read and then compared (one memory read port),
// then the slot's count and sum are read and updated. An item with
// batch_last whose key got a slot runs the bit-serial divider (one quotient
// bit per cycle); every item with batch_last then drives result_key,
// mean_value, sample_count and status for exactly one cycle with done high.
// The receiver cannot stall: the result is taken in the cycle done is high.
// A new key whose table is full is dropped and the batch reports status 1.
// Reset clears all slot valid flags and the drop flag at once; no clearing
// pass is needed and start is honored in the first cycle after reset.
module keyed_running_average #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [kra_pkg::KeyW-1:0]          sample_key,
  input  logic signed [kra_pkg::ValW-1:0]   sample_value,
  input  logic                              batch_last,
  output logic                              done,
  output logic [kra_pkg::KeyW-1:0]          result_key,
  output logic signed [kra_pkg::ValW-1:0]   mean_value,
  output logic [kra_pkg::CntW-1:0]          sample_count,
  output logic                              status
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  kra_pkg::state_t state, state_next;

  logic [kra_pkg::KeyW-1:0]  slot_key   [TABLE_ENTRIES];
  logic [kra_pkg::CntW-1:0]  slot_count [TABLE_ENTRIES];
  logic [kra_pkg::SumW-1:0]  slot_sum   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]  slot_valid;

  logic [kra_pkg::KeyW-1:0]  in_key;
  logic [kra_pkg::ValW-1:0]  in_val;
  logic                      in_last;
  logic [IW-1:0]             idx;
  logic [IW-1:0]             hit_idx;
  logic [IW-1:0]             free_idx;
  logic                      hit_found;
  logic                      free_found;
  logic                      dropped;
  logic [kra_pkg::KeyW-1:0]  key_rd;
  logic [kra_pkg::CntW-1:0]  cnt_rd;
  logic [kra_pkg::SumW-1:0]  sum_rd;
  logic [kra_pkg::CntW-1:0]  new_cnt;
  logic [kra_pkg::SumW-1:0]  new_sum;
  logic [IW-1:0]             sel_idx;
  logic [kra_pkg::SumW-1:0]  val_ext;
  logic [kra_pkg::SumW-1:0]  add_s;
  logic                      add_ovf;
  logic [kra_pkg::SumW-1:0]  sat_sum;
  logic                      last_slot;
  logic                      div_start;
  logic                      div_done;
  logic [kra_pkg::ValW-1:0]  div_mean;
  logic [kra_pkg::SumW-1:0]  div_mag;
  logic                      div_started;

  assign sel_idx   = hit_found ? hit_idx : free_idx;
  assign val_ext   = {{(kra_pkg::SumW-kra_pkg::ValW){in_val[kra_pkg::ValW-1]}}, in_val};
  assign add_s     = sum_rd + val_ext;
  assign add_ovf   = (sum_rd[kra_pkg::SumW-1] == val_ext[kra_pkg::SumW-1]) &&
                     (add_s[kra_pkg::SumW-1] != sum_rd[kra_pkg::SumW-1]);
  assign sat_sum   = !add_ovf ? add_s :
                     (val_ext[kra_pkg::SumW-1] ? {1'b1, {(kra_pkg::SumW-1){1'b0}}}
                                               : {1'b0, {(kra_pkg::SumW-1){1'b1}}});
  assign last_slot = (idx == IW'(TABLE_ENTRIES - 1));
  assign div_mag   = new_sum[kra_pkg::SumW-1] ? (64'd0 - new_sum) : new_sum;

  always_comb begin
    state_next = state;
    case (state)
      kra_pkg::S_IDLE:    if (start) state_next = kra_pkg::S_RD_KEY;
      kra_pkg::S_RD_KEY:  state_next = kra_pkg::S_CMP_KEY;
      kra_pkg::S_CMP_KEY: state_next = last_slot ? kra_pkg::S_RD_DATA : kra_pkg::S_RD_KEY;
      kra_pkg::S_RD_DATA: begin
        if (hit_found || free_found) state_next = kra_pkg::S_UPDATE;
        else state_next = in_last ? kra_pkg::S_OUT : kra_pkg::S_IDLE;
      end
      kra_pkg::S_UPDATE:  state_next = in_last ? kra_pkg::S_DIV : kra_pkg::S_IDLE;
      kra_pkg::S_DIV:     if (div_done) state_next = kra_pkg::S_OUT;
      kra_pkg::S_OUT:     state_next = kra_pkg::S_IDLE;
      default:            state_next = kra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != kra_pkg::S_IDLE);
    done      = (state == kra_pkg::S_OUT);
    div_start = (state == kra_pkg::S_DIV) && !div_started;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kra_pkg::S_IDLE;
      slot_valid  <= '0;
      dropped     <= 1'b0;
      div_started <= 1'b0;
      hit_found   <= 1'b0;
      free_found  <= 1'b0;
      idx         <= '0;
    end else begin
      state <= state_next;
      case (state)
        kra_pkg::S_IDLE: begin
          idx        <= '0;
          hit_found  <= 1'b0;
          free_found <= 1'b0;
        end
        kra_pkg::S_CMP_KEY: begin
          if (slot_valid[idx] && key_rd == in_key && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= idx;
          end
          if (!slot_valid[idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (!last_slot) idx <= idx + 1'b1;
        end
        kra_pkg::S_RD_DATA: begin
          if (!hit_found && !free_found) dropped <= 1'b1;
        end
        kra_pkg::S_UPDATE: begin
          if (!hit_found) slot_valid[sel_idx] <= 1'b1;
        end
        kra_pkg::S_DIV: begin
          div_started <= 1'b1;
        end
        kra_pkg::S_OUT: begin
          dropped     <= 1'b0;
          div_started <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == kra_pkg::S_IDLE && start) begin
      in_key  <= sample_key;
      in_val  <= sample_value;
      in_last <= batch_last;
    end
    if (state == kra_pkg::S_RD_KEY) key_rd <= slot_key[idx];
    if (state == kra_pkg::S_RD_DATA) begin
      cnt_rd <= slot_count[sel_idx];
      sum_rd <= slot_sum[sel_idx];
    end
    if (state == kra_pkg::S_UPDATE) begin
      if (!hit_found) begin
        slot_key[sel_idx]   <= in_key;
        slot_count[sel_idx] <= 32'd1;
        slot_sum[sel_idx]   <= val_ext;
        new_cnt             <= 32'd1;
        new_sum             <= val_ext;
      end else if (cnt_rd != 32'hFFFF_FFFF) begin
        slot_count[sel_idx] <= cnt_rd + 32'd1;
        slot_sum[sel_idx]   <= sat_sum;
        new_cnt             <= cnt_rd + 32'd1;
        new_sum             <= sat_sum;
      end else begin
        new_cnt <= cnt_rd;
        new_sum <= sum_rd;
      end
    end
    if (state == kra_pkg::S_RD_DATA && !hit_found && !free_found) begin
      result_key   <= in_key;
      mean_value   <= '0;
      sample_count <= '0;
      status       <= 1'b1;
    end
    if (state == kra_pkg::S_DIV && div_done) begin
      result_key   <= in_key;
      mean_value   <= div_mean;
      sample_count <= new_cnt;
      status       <= dropped;
    end
  end

  kra_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .mag     (div_mag),
    .neg     (new_sum[kra_pkg::SumW-1]),
    .divisor (new_cnt),
    .done    (div_done),
    .mean    (div_mean)
  );

endmodule
